[rtl/core/letter_frequency_mode_assert.svh]
// Assertion macros shared by the letter frequency checker.
`ifndef LETTER_FREQUENCY_MODE_ASSERT_SVH
`define LETTER_FREQUENCY_MODE_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define LFM_ASSERT_NOW(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// The condition must hold in the cycle after the trigger.
`define LFM_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

[rtl/core/lfm_pkg.sv]
// Package with the types, constants and helper functions of the letter frequency block.
`default_nettype none
package lfm_pkg;

	localparam int NUM_BINS    = 52;
	localparam int HALF_BINS   = 26;
	localparam int BIN_W       = $clog2(NUM_BINS);
	localparam int CNT_W       = 8;
	localparam int CHAR_W      = 8;
	localparam int LETTER_W    = 7;
	localparam int MAX_LEN_DEF = 128;

	localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7a;
	localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5a;

	// Bin lookup of one input byte.
	typedef struct packed {
		logic             hit;
		logic [BIN_W-1:0] bin;
	} bin_sel_t;

	// Requests from the sequencer to the count store.
	typedef struct packed {
		logic             we;
		logic [BIN_W-1:0] waddr;
		logic [CNT_W-1:0] wdata;
		logic [BIN_W-1:0] raddr;
		logic             clr;
	} ram_req_t;

	// Lowercase letters map to bins 0..25, uppercase to 26..51.
	function automatic bin_sel_t char_to_bin(input logic [CHAR_W-1:0] c);
		bin_sel_t r;
		r.hit = 1'b0;
		r.bin = '0;
		if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
			r.hit = 1'b1;
			r.bin = BIN_W'(c - CH_LOWER_A);
		end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			r.hit = 1'b1;
			r.bin = BIN_W'(c - CH_UPPER_A) + BIN_W'(HALF_BINS);
		end
		return r;
	endfunction

	// ASCII code of the letter counted in a bin.
	function automatic logic [LETTER_W-1:0] bin_to_letter(input logic [BIN_W-1:0] b);
		logic [LETTER_W-1:0] r;
		if (b < BIN_W'(HALF_BINS)) begin
			r = LETTER_W'(CH_LOWER_A) + LETTER_W'(b);
		end else begin
			r = LETTER_W'(CH_UPPER_A) + LETTER_W'(b - BIN_W'(HALF_BINS));
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/core/letter_frequency_mode.sv]
// Top level of the letter frequency block: count store, its valid bits and the sequencer.
//
// Usage: a sentence arrives one byte per input transaction on char_code, with
// end_of_sentence set on its final byte. Letters are counted in 52 bins (a..z,
// then A..Z), saturating at min(MAX_LEN, 255); other bytes are ignored.
// Each byte is read and then updated in its bin of the count RAM, so
// in_stall is high in the cycle after every accepted transaction.
// On the final byte the sequencer reads all 52 bins through the single RAM
// read port, one bin after another, to find the maximum. It then reads the
// bins again up to the last one holding the maximum and emits one output
// transaction per letter with that count, in bin order, final_letter set on the last.
// If no letter occurred, all 52 letters are emitted with count zero.
// The output register holds a letter while out_stall is high; the scan waits.
// The input stays stalled until the last letter is loaded into the output
// register. Reset clears the valid bits of the bins, so every bin reads as
// zero; the valid bits are cleared again at the end of each sentence.
`default_nettype none
module letter_frequency_mode import lfm_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [CHAR_W-1:0]   char_code,
	input  wire logic                end_of_sentence,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [LETTER_W-1:0]      letter_code,
	output logic [CNT_W-1:0]         occurrences,
	output logic                     final_letter
);

	ram_req_t            req;
	logic [CNT_W-1:0]    ram_rdata;
	logic [CNT_W-1:0]    rd_count;
	logic [NUM_BINS-1:0] vbit_q;
	logic                rvalid_q;

	lfm_ram #(
		.WIDTH (CNT_W),
		.DEPTH (NUM_BINS)
	) u_ram (
		.clk   (clk),
		.we    (req.we),
		.waddr (req.waddr),
		.wdata (req.wdata),
		.raddr (req.raddr),
		.rdata (ram_rdata)
	);

	// Per-bin valid bits; a bin never written since the last clear reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vbit_q   <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (req.clr) begin
				vbit_q <= '0;
			end else if (req.we) begin
				vbit_q[req.waddr] <= 1'b1;
			end
			rvalid_q <= vbit_q[req.raddr];
		end
	end

	assign rd_count = rvalid_q ? ram_rdata : '0;

	lfm_seq #(
		.MAX_LEN (MAX_LEN)
	) u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.char_code       (char_code),
		.end_of_sentence (end_of_sentence),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.letter_code     (letter_code),
		.occurrences     (occurrences),
		.final_letter    (final_letter),
		.rd_count        (rd_count),
		.req             (req)
	);

endmodule
`default_nettype wire

[rtl/core/lfm_ram.sv]
// Generic single write port RAM with a registered read port.
`default_nettype none
module lfm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 52
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[rtl/core/lfm_seq.sv]
// Sequencer: counts bytes, scans the bins for the maximum and emits the most frequent letters.
`default_nettype none
module lfm_seq import lfm_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [CHAR_W-1:0]   char_code,
	input  wire logic                end_of_sentence,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [LETTER_W-1:0]      letter_code,
	output logic [CNT_W-1:0]         occurrences,
	output logic                     final_letter,
	input  wire logic [CNT_W-1:0]    rd_count,
	output ram_req_t                 req
);

	localparam int CNT_LIM_I = (MAX_LEN > 255) ? 255 : MAX_LEN;
	localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(CNT_LIM_I);
	localparam logic [BIN_W-1:0] LAST_BIN  = BIN_W'(NUM_BINS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD,
		ST_MAX_RD,
		ST_MAX_CMP,
		ST_EMIT_RD,
		ST_EMIT_CMP
	} state_t;

	state_t              state_q;
	logic [BIN_W-1:0]    idx_q;
	logic [BIN_W-1:0]    bin_q;
	logic                hit_q;
	logic                eos_q;
	logic [CNT_W-1:0]    max_q;
	logic [BIN_W-1:0]    last_q;
	logic                out_valid_q;
	logic [LETTER_W-1:0] letter_q;
	logic [CNT_W-1:0]    occ_q;
	logic                final_q;

	bin_sel_t            sel;
	logic                out_free;
	logic                match;
	logic                load_out;

	assign sel      = char_to_bin(char_code);
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign match    = (rd_count == max_q);
	assign load_out = (state_q == ST_EMIT_CMP) && match && out_free;

	assign out_valid    = out_valid_q;
	assign letter_code  = letter_q;
	assign occurrences  = occ_q;
	assign final_letter = final_q;

	// Store requests: read the incoming byte's bin while idle, else the scan index.
	always_comb begin
		req.raddr = (state_q == ST_IDLE) ? sel.bin : idx_q;
		req.we    = (state_q == ST_UPD) && hit_q && (rd_count < CNT_LIMIT);
		req.waddr = bin_q;
		req.wdata = rd_count + CNT_W'(1);
		req.clr   = load_out && (idx_q == last_q);
	end

	// State, scan registers and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			bin_q       <= '0;
			hit_q       <= 1'b0;
			eos_q       <= 1'b0;
			max_q       <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
			letter_q    <= '0;
			occ_q       <= '0;
			final_q     <= 1'b0;
		end else begin
			// The output is offered when a letter is loaded and dropped once taken.
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						hit_q   <= sel.hit;
						bin_q   <= sel.bin;
						eos_q   <= end_of_sentence;
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (eos_q) begin
						idx_q   <= '0;
						max_q   <= '0;
						last_q  <= '0;
						state_q <= ST_MAX_RD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_MAX_RD: begin
					state_q <= ST_MAX_CMP;
				end
				ST_MAX_CMP: begin
					// Track the maximum and the last bin that holds it.
					if (rd_count > max_q) begin
						max_q  <= rd_count;
						last_q <= idx_q;
					end else if (match) begin
						last_q <= idx_q;
					end
					if (idx_q == LAST_BIN) begin
						idx_q   <= '0;
						state_q <= ST_EMIT_RD;
					end else begin
						idx_q   <= idx_q + BIN_W'(1);
						state_q <= ST_MAX_RD;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_CMP;
				end
				ST_EMIT_CMP: begin
					if (match) begin
						// Wait here until the output register can take the letter.
						if (out_free) begin
							letter_q    <= bin_to_letter(idx_q);
							occ_q       <= max_q;
							final_q     <= (idx_q == last_q);
							if (idx_q == last_q) begin
								state_q <= ST_IDLE;
							end else begin
								idx_q   <= idx_q + BIN_W'(1);
								state_q <= ST_EMIT_RD;
							end
						end
					end else begin
						idx_q   <= idx_q + BIN_W'(1);
						state_q <= ST_EMIT_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/core/lfm_checker.sv]
// Port-level checker of the letter frequency block and its bind to the top level.
`default_nettype none
`include "letter_frequency_mode_assert.svh"
module lfm_checker import lfm_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_stall,
	input wire logic [CHAR_W-1:0]   char_code,
	input wire logic                end_of_sentence,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire logic [LETTER_W-1:0] letter_code,
	input wire logic [CNT_W-1:0]    occurrences,
	input wire logic                final_letter
);

	// A stalled output transaction stays offered.
	`LFM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "output dropped under stall")

	// A stalled output transaction keeps its payload.
	`LFM_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(letter_code) && $stable(occurrences) && $stable(final_letter), "output payload changed under stall")

	// Every byte keeps the input stalled while its bin is updated.
	`LFM_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall, "input taken on back-to-back cycles")

	// No new byte is taken while a run of letters is still being emitted.
	`LFM_ASSERT_NOW(a_run_blocks_in, out_valid && !final_letter, in_stall, "input open during a letter run")

endmodule

bind letter_frequency_mode lfm_checker u_lfm_checker (.*);
`default_nettype wire

[tb/letter_frequency_mode_checker.sv]
`timescale 1ns / 1ps
// Checker that predicts the most frequent letters of each sentence and compares the block's output.
module letter_frequency_mode_checker import lfm_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_stall,
	input  wire logic [CHAR_W-1:0]   char_code,
	input  wire logic                end_of_sentence,
	input  wire logic                out_valid,
	input  wire logic                out_stall,
	input  wire logic [LETTER_W-1:0] letter_code,
	input  wire logic [CNT_W-1:0]    occurrences,
	input  wire logic                final_letter,
	output int                       fail_count,
	output int                       letters_due,
	output int                       sentences_done,
	output int                       letters_checked,
	output int                       ceiling_hits
);

	// A bin stops counting at MAX_LEN, or at 255 where MAX_LEN does not fit in 8 bits.
	localparam int TALLY_CEIL = (MAX_LEN > 255) ? 255 : MAX_LEN;

	typedef struct packed {
		logic [LETTER_W-1:0] letter;
		logic [CNT_W-1:0]    count;
		logic                last;
	} mode_letter_t;

	logic [CNT_W-1:0] letter_tally [NUM_BINS];
	mode_letter_t     mode_letters_due [$];

	initial begin
		fail_count = 0;
		letters_due = 0;
		sentences_done = 0;
		letters_checked = 0;
		ceiling_hits = 0;
	end

	// Prints one line per mismatch and counts it.
	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		fail_count++;
	endtask

	// Counts one byte; on the final byte it queues every letter of the mode in bin order.
	task automatic tally_byte(input logic [CHAR_W-1:0] c, input logic eos);
		int bin_idx;
		int peak;
		int last_idx;
		mode_letter_t m;
		bin_idx = -1;
		if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
			bin_idx = int'(c - CH_LOWER_A);
		end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			bin_idx = int'(c - CH_UPPER_A) + HALF_BINS;
		end
		if (bin_idx >= 0 && letter_tally[bin_idx] < TALLY_CEIL) begin
			letter_tally[bin_idx] = letter_tally[bin_idx] + 1'b1;
		end
		if (eos) begin
			peak = 0;
			last_idx = 0;
			for (int k = 0; k < NUM_BINS; k++) begin
				if (letter_tally[k] > peak) begin
					peak = letter_tally[k];
				end
			end
			for (int k = 0; k < NUM_BINS; k++) begin
				if (letter_tally[k] == peak) begin
					last_idx = k;
				end
			end
			// With no letter at all the peak is zero and every bin matches.
			for (int k = 0; k < NUM_BINS; k++) begin
				if (letter_tally[k] == peak) begin
					if (k < HALF_BINS) begin
						m.letter = LETTER_W'(CH_LOWER_A) + LETTER_W'(k);
					end else begin
						m.letter = LETTER_W'(CH_UPPER_A) + LETTER_W'(k - HALF_BINS);
					end
					m.count = CNT_W'(peak);
					m.last = (k == last_idx);
					mode_letters_due.push_back(m);
				end
				letter_tally[k] = '0;
			end
			sentences_done++;
		end
	endtask

	// Watches both channels at every rising edge.
	always @(posedge clk or negedge arst_n) begin : watch
		mode_letter_t due;
		if (!arst_n) begin
			for (int k = 0; k < NUM_BINS; k++) begin
				letter_tally[k] = '0;
			end
			mode_letters_due.delete();
		end else begin
			if (in_valid && !in_stall) begin
				tally_byte(char_code, end_of_sentence);
			end
			if (out_valid && !out_stall) begin
				if (mode_letters_due.size() == 0) begin
					report_mismatch($sformatf("unexpected letter 0x%0h with count %0d",
						letter_code, occurrences));
				end else begin
					due = mode_letters_due.pop_front();
					letters_checked++;
					if (due.count == TALLY_CEIL) begin
						ceiling_hits++;
					end
					if (letter_code !== due.letter) begin
						report_mismatch($sformatf("letter_code 0x%0h, expected 0x%0h",
							letter_code, due.letter));
					end
					if (occurrences !== due.count) begin
						report_mismatch($sformatf("occurrences %0d for 0x%0h, expected %0d",
							occurrences, due.letter, due.count));
					end
					if (final_letter !== due.last) begin
						report_mismatch($sformatf("final_letter %b for 0x%0h, expected %b",
							final_letter, due.letter, due.last));
					end
				end
			end
		end
		letters_due = mode_letters_due.size();
	end

endmodule

[tb/letter_frequency_mode_tb.sv]
`timescale 1ns / 1ps
// Testbench top: clock, reset, sentence stimulus, output stalls and the verdict.
module letter_frequency_mode_tb;
	import lfm_pkg::*;

	localparam int MAX_LEN      = MAX_LEN_DEF;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_BYTES = 390;
	// A flood of one letter runs two past the count ceiling.
	localparam int FLOOD_RUN    = ((MAX_LEN > 255) ? 255 : MAX_LEN) + 2;

	typedef enum int {SENT_WORDS, SENT_NOISE, SENT_BLANK, SENT_FLOOD} sentence_kind_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [CHAR_W-1:0]   char_code;
	logic                end_of_sentence;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [LETTER_W-1:0] letter_code;
	logic [CNT_W-1:0]    occurrences;
	logic                final_letter;

	int fail_count;
	int letters_due;
	int sentences_done;
	int letters_checked;
	int ceiling_hits;

	int send_idle_pct = 20;
	int recv_idle_pct = 50;
	int bytes_sent = 0;
	int cycle_count = 0;

	letter_frequency_mode #(
		.MAX_LEN(MAX_LEN)
	) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.char_code      (char_code),
		.end_of_sentence(end_of_sentence),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.letter_code    (letter_code),
		.occurrences    (occurrences),
		.final_letter   (final_letter)
	);

	letter_frequency_mode_checker #(
		.MAX_LEN(MAX_LEN)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.char_code      (char_code),
		.end_of_sentence(end_of_sentence),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.letter_code    (letter_code),
		.occurrences    (occurrences),
		.final_letter   (final_letter),
		.fail_count     (fail_count),
		.letters_due    (letters_due),
		.sentences_done (sentences_done),
		.letters_checked(letters_checked),
		.ceiling_hits   (ceiling_hits)
	);

	// 20 ns clock.
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// The receiver stalls at random, at the rate of the current phase.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// Cycle counter and watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d letters still due", cycle_count, letters_due);
		$display("simulation failed");
		$finish;
	end

	// Any letter, either case.
	function automatic logic [CHAR_W-1:0] any_letter();
		logic [CHAR_W-1:0] base;
		base = $urandom_range(1) ? CH_UPPER_A : CH_LOWER_A;
		return base + CHAR_W'($urandom_range(25));
	endfunction

	// Offers one byte, with random idle cycles first, and holds it until accepted.
	task automatic send_byte(input logic [CHAR_W-1:0] c, input logic eos);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		char_code <= c;
		end_of_sentence <= eos;
		bytes_sent++;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Sends one sentence of the given kind, flagging its last byte.
	task automatic send_sentence(input sentence_kind_t kind, input int len);
		logic [CHAR_W-1:0] favorite;
		logic [CHAR_W-1:0] c;
		int r;
		favorite = any_letter();
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(9);
			case (kind)
			SENT_NOISE: c = CHAR_W'($urandom_range(255));
			SENT_BLANK: begin
				do c = CHAR_W'($urandom_range(255));
				while ((c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
					(c >= CH_UPPER_A && c <= CH_UPPER_Z));
			end
			SENT_FLOOD: c = (i < FLOOD_RUN) ? favorite : CHAR_W'($urandom_range(255));
			default: begin
				// Mostly a favorite letter, so the mode is often shared between cases.
				if (r < 4) begin
					c = favorite;
				end else if (r < 6) begin
					c = favorite ^ 8'h20;
				end else if (r < 8) begin
					c = any_letter();
				end else if (r == 8) begin
					c = 8'h20;
				end else begin
					c = CHAR_W'($urandom_range(255));
				end
			end
			endcase
			send_byte(c, i == len - 1);
		end
	endtask

	initial begin : stimulus
		int first_random;
		int rnd_sent;
		int r;
		logic flood_done;
		in_valid = 1'b0;
		char_code = '0;
		end_of_sentence = 1'b0;
		arst_n = 1'b0;
		flood_done = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// A single letter that is also the final byte.
		send_byte("a", 1'b1);
		// A sentence without letters: all 52 letters come out with count zero.
		send_byte(8'h00, 1'b1);
		// A three-way tie across both cases, ended by a byte above 127.
		send_byte("A", 1'b0);
		send_byte("z", 1'b0);
		send_byte("Z", 1'b0);
		send_byte(8'hff, 1'b1);
		// Neighbors of the letter ranges are ignored; a non-mode letter ends it.
		send_byte(8'h60, 1'b0);
		send_byte(8'h7b, 1'b0);
		send_byte(8'h40, 1'b0);
		send_byte(8'h5b, 1'b0);
		send_byte(8'h0a, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'he1, 1'b0);
		send_byte("b", 1'b0);
		send_byte("b", 1'b0);
		send_byte("y", 1'b1);
		// The same letter in both cases ties at two.
		send_byte("m", 1'b0);
		send_byte("M", 1'b0);
		send_byte("m", 1'b0);
		send_byte("M", 1'b1);

		// Random sentences in three idling phases.
		first_random = bytes_sent;
		rnd_sent = 0;
		while (rnd_sent < RANDOM_BYTES) begin
			if (rnd_sent >= 2 * RANDOM_BYTES / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (rnd_sent >= RANDOM_BYTES / 3) begin
				send_idle_pct = 50;
				recv_idle_pct = 20;
			end
			r = $urandom_range(19);
			if (!flood_done && rnd_sent >= RANDOM_BYTES / 3) begin
				flood_done = 1'b1;
				send_sentence(SENT_FLOOD, FLOOD_RUN + $urandom_range(5));
			end else if (r < 13) begin
				send_sentence(SENT_WORDS, $urandom_range(12, 1));
			end else if (r < 16) begin
				send_sentence(SENT_NOISE, $urandom_range(8, 1));
			end else begin
				send_sentence(SENT_BLANK, $urandom_range(4, 1));
			end
			rnd_sent = bytes_sent - first_random;
		end
		in_valid <= 1'b0;

		// Drain the outstanding letters, then watch for strays.
		while (letters_due != 0) @(negedge clk);
		repeat (300) @(negedge clk);

		$display("Sent %0d bytes in %0d sentences under three stall patterns.",
			bytes_sent, sentences_done);
		$display("Checked %0d mode letters, %0d of them at the count ceiling.",
			letters_checked, ceiling_hits);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/lfm_pkg.sv
rtl/core/lfm_ram.sv
rtl/core/lfm_seq.sv
rtl/core/letter_frequency_mode.sv
rtl/core/lfm_checker.sv
tb/letter_frequency_mode_checker.sv
tb/letter_frequency_mode_tb.sv
